FILE: hw/rtl/sgr_pkg.sv
// Shared types and constants for the stream group reverser.
// No dependencies; imported by the controller, datapath and top level.
package sgr_pkg;

  localparam int unsigned CFG_W          = 5;
  localparam int unsigned REG_GROUP_SIZE = 0;
  localparam logic [CFG_W-1:0] GROUP_SIZE_RST = CFG_W'(1);

  // controller -> datapath
  typedef struct packed {
    logic wr;     // store the incoming word and bump the fill count
    logic start;  // close the buffer and arm the readout
    logic rev;    // readout newest first
    logic rd;     // read one buffered word into the output register
  } sgr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic grp_full;  // the incoming word completes a group
    logic tail;      // output register holds the last word of the run
  } sgr_stat_t;

endpackage

FILE: hw/rtl/sgr_ctrl.sv
// Sequencing FSM for the stream group reverser: accepts words, launches
// readouts and paces the output word stream. Depends on sgr_pkg.
module sgr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sgr_pkg::sgr_stat_t stat_i,
  output sgr_pkg::sgr_cmd_t  cmd_o
);
  import sgr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_SEND
  } state_e;

  state_e state_q;
  logic   rdy_q;
  logic   vld_q;
  logic   take;
  logic   flush;
  logic   sent;

  assign take  = (state_q == ST_IDLE) && in_valid_i;
  assign flush = stat_i.grp_full || in_last_i;
  assign sent  = (state_q == ST_SEND) && out_ready_i;

  always_comb begin
    cmd_o       = '0;
    cmd_o.wr    = take;
    cmd_o.start = take && flush;
    cmd_o.rev   = stat_i.grp_full;
    cmd_o.rd    = (state_q == ST_RD) || (sent && !stat_i.tail);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rdy_q   <= 1'b1;
      vld_q   <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (take && flush) begin
            state_q <= ST_RD;
            rdy_q   <= 1'b0;
          end
        end
        ST_RD: begin
          state_q <= ST_SEND;
          vld_q   <= 1'b1;
        end
        ST_SEND: begin
          if (sent && stat_i.tail) begin
            state_q <= ST_IDLE;
            vld_q   <= 1'b0;
            rdy_q   <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          vld_q   <= 1'b0;
          rdy_q   <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o  = rdy_q;
  assign out_valid_o = vld_q;

endmodule

FILE: hw/rtl/sgr_dpath.sv
// Datapath for the stream group reverser: word buffer memory, fill count,
// readout pointer and output register. Depends on sgr_pkg.
module sgr_dpath #(
  parameter int unsigned MAX_GROUP = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [sgr_pkg::CFG_W-1:0]  group_size_i,
  input  logic [WORD_BITS-1:0]       in_word_i,
  input  logic                       in_last_i,
  input  sgr_pkg::sgr_cmd_t          cmd_i,
  output sgr_pkg::sgr_stat_t         stat_o,
  output logic [WORD_BITS-1:0]       out_word_o,
  output logic                       run_end_o,
  output logic                       seq_end_o
);
  import sgr_pkg::*;

  localparam int unsigned AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int unsigned FW = $clog2(MAX_GROUP + 1);
  localparam int unsigned CW = ((FW > CFG_W) ? FW : CFG_W) + 1;

  logic [WORD_BITS-1:0] mem_q [MAX_GROUP];
  logic [WORD_BITS-1:0] word_q;

  logic [FW-1:0] fill_q, fill_d;
  logic [FW-1:0] left_q, left_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic          rev_q, last_q, tail_q;
  logic [FW-1:0] fill_inc;
  logic [CW-1:0] g_eff;

  // zero acts as one, oversize saturates to the buffer depth
  always_comb begin
    if (group_size_i == '0) begin
      g_eff = CW'(1);
    end else if (CW'(group_size_i) > CW'(MAX_GROUP)) begin
      g_eff = CW'(MAX_GROUP);
    end else begin
      g_eff = CW'(group_size_i);
    end
  end

  assign fill_inc        = fill_q + FW'(1);
  assign stat_o.grp_full = CW'(fill_inc) >= g_eff;
  assign stat_o.tail     = tail_q;

  always_comb begin
    fill_d = fill_q;
    left_d = left_q;
    ptr_d  = ptr_q;
    if (cmd_i.start) begin
      fill_d = '0;
      left_d = fill_inc;
      ptr_d  = cmd_i.rev ? fill_q[AW-1:0] : '0;
    end else if (cmd_i.wr) begin
      fill_d = fill_inc;
    end else if (cmd_i.rd) begin
      left_d = left_q - FW'(1);
      ptr_d  = rev_q ? ptr_q - AW'(1) : ptr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      left_q <= '0;
      ptr_q  <= '0;
      rev_q  <= 1'b0;
      last_q <= 1'b0;
      tail_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      left_q <= left_d;
      ptr_q  <= ptr_d;
      if (cmd_i.start) begin
        rev_q  <= cmd_i.rev;
        last_q <= in_last_i;
      end
      if (cmd_i.rd) begin
        tail_q <= (left_q == FW'(1));
      end
    end
  end

  // fill count stays below the depth before each write
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[fill_q[AW-1:0]] <= in_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      word_q <= mem_q[ptr_q];
    end
  end

  assign out_word_o = word_q;
  assign run_end_o  = tail_q;
  assign seq_end_o  = tail_q && last_q;

endmodule

FILE: hw/rtl/stream_group_reverser.sv
// Stream group reverser top level: APB group size register, controller and
// datapath. Depends on sgr_pkg, sgr_ctrl and sgr_dpath.
//
// Words are buffered until group_size of them are held, then that group is
// sent newest first; a sequence that ends (tlast) on a partial group sends
// the leftover words in arrival order. A word that closes no group is taken
// into the buffer. A word that closes a group or a sequence is taken, the
// first word is read into the output register in ST_RD, and the run then goes
// out at one word per cycle while the sink is ready; the single read port of the
// buffer paces the readout. No new word is taken until the last word of the
// run has been handed over. m_axis_tuser_o marks the last word of each run,
// m_axis_tlast_o the last word of the sequence. group_size 0 acts as 1 and
// values above MAX_GROUP act as MAX_GROUP; write it only while idle.
module stream_group_reverser #(
  parameter int unsigned MAX_GROUP = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // slave side: tdata = {pad, data_word}, tlast = seq_end
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [((WORD_BITS+7)/8)*8-1:0]       s_axis_tdata_i,  // data_word
  input  logic                                 s_axis_tlast_i,
  // master side: tdata = {pad, out_word}, tuser = run_end, tlast = out_seq_end
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [((WORD_BITS+7)/8)*8-1:0]       m_axis_tdata_o,  // out_word
  output logic                                 m_axis_tuser_o,  // run_end
  output logic                                 m_axis_tlast_o,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [1:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import sgr_pkg::*;

  localparam int unsigned DW = ((WORD_BITS + 7) / 8) * 8;

  logic [CFG_W-1:0]     group_size_q;
  logic [WORD_BITS-1:0] out_word;
  logic                 cfg_wr;
  sgr_cmd_t             cmd;
  sgr_stat_t            stat;

  assign pready = 1'b1;
  // a single register, so every address decodes to it
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = 32'(group_size_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= GROUP_SIZE_RST;
    end else if (cfg_wr && (32'(paddr >> 2) == REG_GROUP_SIZE)) begin
      group_size_q <= pwdata[CFG_W-1:0];
    end
  end

  sgr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sgr_dpath #(
    .MAX_GROUP(MAX_GROUP),
    .WORD_BITS(WORD_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .group_size_i(group_size_q),
    .in_word_i   (s_axis_tdata_i[WORD_BITS-1:0]),
    .in_last_i   (s_axis_tlast_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_word_o  (out_word),
    .run_end_o   (m_axis_tuser_o),
    .seq_end_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = DW'(out_word);

  // input and output sides never open together
  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while a word is offered");

  // a run keeps going until its last word is taken
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tuser_o |=> m_axis_tvalid_o)
    else $error("run stopped before its last word");

  // sequence end only on the last word of a run
  a_seq_end_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o)
    else $error("sequence end away from run end");

  // the input reopens right after the last word of a run is taken
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tuser_o |=> s_axis_tready_o)
    else $error("input not reopened after run");

endmodule
